// ===== rtl/core/qwt_pkg.sv =====
// Shared constants, types and helpers of the quoted word tokenizer.
package qwt_pkg;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_EOW  = 2'd1;
    localparam logic [1:0] KIND_EOL  = 2'd2;

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
    localparam logic [1:0] QUOTE_SINGLE = 2'd2;

    localparam logic [7:0] MAX_WORDS_RESET = 8'd16;
    localparam logic [7:0] COUNT_MAX       = 8'hFF;

    // Results per input item at most, and the output queue that holds them
    localparam int MAX_RES = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] word_number;
        logic       over_limit;
        logic       last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0]                 cnt;
        t_result [MAX_RES-1:0]      res;
    } t_push;

    function automatic t_result mk_result(input logic [1:0] kind, input logic [7:0] data,
                                          input logic [7:0] num, input logic over);
        t_result r;
        r.kind        = kind;
        r.data_byte   = data;
        r.word_number = num;
        r.over_limit  = over;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/core/qwt_if.sv =====
// Valid/ready channel interfaces for characters in and tokens out.
interface qwt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_line;

    modport source (output valid, output char_code, output end_of_line, input ready);
    modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

interface qwt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] word_number;
    logic       over_limit;
    logic       last_of_run;

    modport source (output valid, output kind, output data_byte, output word_number,
                    output over_limit, output last_of_run, input ready);
    modport sink   (input valid, input kind, input data_byte, input word_number,
                    input over_limit, input last_of_run, output ready);
endinterface

// ===== rtl/core/quoted_word_tokenizer.sv =====
// Quoted word tokenizer top level: splits a command line into words, one character per transfer.
// Takes one character per input transfer and splits the line into words on spaces and tabs,
// honouring double and single quotes and backslash escapes; every kept character leaves tagged
// with its word number, followed by end of word and end of line marks. While the output keeps
// up, the block accepts a new ordinary character every cycle; with the result queue empty its
// result appears on the output the cycle after the transfer. An end of line item yields up to
// three results, which drain one per cycle while the output is ready from a four-entry result
// queue; input is accepted while that queue holds at most one result, so an end of line holds
// off input until the queue has drained back to one result, and output stalls add to that.
// max_words is written through i_cfg_wr_en/i_cfg_wr_data and resets to 16.
module quoted_word_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    qwt_in_if.sink     i_in,
    qwt_out_if.source  o_out
);

    logic [7:0]     r_max_words;
    logic           acc;
    logic           space;
    qwt_pkg::t_push push;

    assign i_in.ready = space;
    assign acc        = i_in.valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_words <= qwt_pkg::MAX_WORDS_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_words <= i_cfg_wr_data;
        end
    end

    qwt_lexer u_lexer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_char_code   (i_in.char_code),
        .i_end_of_line (i_in.end_of_line),
        .i_max_words   (r_max_words),
        .o_push        (push)
    );

    qwt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/core/qwt_lexer.sv =====
// Tokenizer state and per-character result generation.
module qwt_lexer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_acc,
    input  logic [7:0]            i_char_code,
    input  logic                  i_end_of_line,
    input  logic [7:0]            i_max_words,
    output qwt_pkg::t_push        o_push
);

    logic       r_inside, n_inside;
    logic [1:0] r_quote,  n_quote;
    logic       r_esc,    n_esc;
    logic [7:0] r_wc,     n_wc;
    logic       r_sat,    n_sat;

    qwt_pkg::t_result [qwt_pkg::MAX_RES-1:0] res;
    logic [1:0] cnt;
    logic [7:0] idx;
    logic       over;
    logic       blank;
    logic [7:0] q_char;

    always_comb begin
        n_inside = r_inside;
        n_quote  = r_quote;
        n_esc    = r_esc;
        n_wc     = r_wc;
        n_sat    = r_sat;
        res      = '0;
        cnt      = 2'd0;
        idx      = 8'd0;
        over     = 1'b0;
        q_char   = qwt_pkg::CH_SQUOTE;
        blank    = (i_char_code == qwt_pkg::CH_SPACE) || (i_char_code == qwt_pkg::CH_TAB);

        if (i_end_of_line) begin
            idx  = r_sat ? qwt_pkg::COUNT_MAX : ((r_wc == 8'd0) ? 8'd0 : r_wc - 8'd1);
            over = idx >= i_max_words;
            // dangling backslash is kept as an ordinary character
            if (r_esc) begin
                res[cnt] = qwt_pkg::mk_result(qwt_pkg::KIND_CHAR, qwt_pkg::CH_BSLASH, idx, over);
                cnt      = cnt + 2'd1;
            end
            if (r_inside) begin
                res[cnt] = qwt_pkg::mk_result(qwt_pkg::KIND_EOW, 8'd0, idx, over);
                cnt      = cnt + 2'd1;
            end
            res[cnt] = qwt_pkg::mk_result(qwt_pkg::KIND_EOL, 8'd0, r_wc,
                                          r_sat || (r_wc > i_max_words));
            cnt      = cnt + 2'd1;
            n_inside = 1'b0;
            n_quote  = qwt_pkg::QUOTE_NONE;
            n_esc    = 1'b0;
            n_wc     = 8'd0;
            n_sat    = 1'b0;
        end else if (r_inside || !blank) begin
            if (!r_inside) begin
                n_inside = 1'b1;
                n_quote  = qwt_pkg::QUOTE_NONE;
                n_esc    = 1'b0;
                if (r_wc == qwt_pkg::COUNT_MAX) begin
                    n_sat = 1'b1;
                end else begin
                    n_wc = r_wc + 8'd1;
                end
            end
            idx  = n_sat ? qwt_pkg::COUNT_MAX : ((n_wc == 8'd0) ? 8'd0 : n_wc - 8'd1);
            over = idx >= i_max_words;
            if (n_esc) begin
                n_esc    = 1'b0;
                res[cnt] = qwt_pkg::mk_result(qwt_pkg::KIND_CHAR, i_char_code, idx, over);
                cnt      = cnt + 2'd1;
            end else if (n_quote != qwt_pkg::QUOTE_NONE) begin
                q_char = (n_quote == qwt_pkg::QUOTE_DOUBLE) ? qwt_pkg::CH_DQUOTE
                                                            : qwt_pkg::CH_SQUOTE;
                if (i_char_code == q_char) begin
                    n_quote = qwt_pkg::QUOTE_NONE;
                end else begin
                    res[cnt] = qwt_pkg::mk_result(qwt_pkg::KIND_CHAR, i_char_code, idx, over);
                    cnt      = cnt + 2'd1;
                end
            end else if (i_char_code == qwt_pkg::CH_DQUOTE) begin
                n_quote = qwt_pkg::QUOTE_DOUBLE;
            end else if (i_char_code == qwt_pkg::CH_SQUOTE) begin
                n_quote = qwt_pkg::QUOTE_SINGLE;
            end else if (i_char_code == qwt_pkg::CH_BSLASH) begin
                n_esc = 1'b1;
            end else if (blank) begin
                res[cnt] = qwt_pkg::mk_result(qwt_pkg::KIND_EOW, 8'd0, idx, over);
                cnt      = cnt + 2'd1;
                n_inside = 1'b0;
            end else begin
                res[cnt] = qwt_pkg::mk_result(qwt_pkg::KIND_CHAR, i_char_code, idx, over);
                cnt      = cnt + 2'd1;
            end
        end

        if (cnt != 2'd0) begin
            res[cnt - 2'd1].last_of_run = 1'b1;
        end
    end

    assign o_push.cnt = i_acc ? cnt : 2'd0;
    assign o_push.res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_quote  <= qwt_pkg::QUOTE_NONE;
            r_esc    <= 1'b0;
            r_wc     <= 8'd0;
            r_sat    <= 1'b0;
        end else if (i_acc) begin
            r_inside <= n_inside;
            r_quote  <= n_quote;
            r_esc    <= n_esc;
            r_wc     <= n_wc;
            r_sat    <= n_sat;
        end
    end

`ifndef ASSERT_OFF
    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_end_of_line) |=> (r_wc == 8'd0 && !r_inside && !r_sat && !r_esc))
        else $error("state not cleared after end of line");
    a_sat_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_wc == qwt_pkg::COUNT_MAX))
        else $error("saturated flag set below full count");
    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_end_of_line) |-> (o_push.cnt != 2'd0 &&
            o_push.res[o_push.cnt - 2'd1].kind == qwt_pkg::KIND_EOL))
        else $error("end of line item must finish with its line mark");
`endif

endmodule

// ===== rtl/core/qwt_outq.sv =====
// Result queue: takes up to three results per cycle while it holds at most one, hands out one per transfer.
module qwt_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qwt_pkg::t_push i_push,
    output logic           o_space,
    qwt_out_if.source      o_out
);

    qwt_pkg::t_result r_mem [qwt_pkg::Q_DEPTH];

    logic [qwt_pkg::Q_PTR_W-1:0] r_wr, n_wr;
    logic [qwt_pkg::Q_PTR_W-1:0] r_rd, n_rd;
    logic [qwt_pkg::Q_CNT_W-1:0] r_cnt, n_cnt;
    logic                        pop;
    qwt_pkg::t_result            head;

    assign head  = r_mem[r_rd];
    assign pop   = o_out.valid && o_out.ready;
    // room for a full end of line burst
    assign o_space = r_cnt <= qwt_pkg::Q_CNT_W'(1);

    assign o_out.valid       = r_cnt != '0;
    assign o_out.kind        = head.kind;
    assign o_out.data_byte   = head.data_byte;
    assign o_out.word_number = head.word_number;
    assign o_out.over_limit  = head.over_limit;
    assign o_out.last_of_run = head.last_of_run;

    always_comb begin
        n_wr  = r_wr + qwt_pkg::Q_PTR_W'(i_push.cnt);
        n_rd  = r_rd + qwt_pkg::Q_PTR_W'(pop);
        n_cnt = r_cnt + qwt_pkg::Q_CNT_W'(i_push.cnt) - qwt_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < qwt_pkg::MAX_RES; i++) begin
            if (qwt_pkg::Q_CNT_W'(i) < qwt_pkg::Q_CNT_W'(i_push.cnt)) begin
                r_mem[r_wr + qwt_pkg::Q_PTR_W'(i)] <= i_push.res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= qwt_pkg::Q_CNT_W'(qwt_pkg::Q_DEPTH))
        else $error("result queue overflow");
    a_push_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_space)
        else $error("push into queue without room");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != qwt_pkg::Q_CNT_W'(qwt_pkg::Q_DEPTH)) |->
            (qwt_pkg::Q_PTR_W'(r_wr - r_rd) == qwt_pkg::Q_PTR_W'(r_cnt)))
        else $error("queue pointers disagree with fill count");
`endif

endmodule
